// ----- src/bsr_pkg.sv -----
// Shared types and constants for the bitmap shape rasterizer.
package bsr_pkg;

  localparam int FIELD_W      = 7;
  localparam int ACT_W        = 3;
  localparam int GRID_DEFAULT = 128;
  localparam int EPSILON      = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_RECT   = 3'd1,
    ACT_LINE   = 3'd2,
    ACT_VLINE  = 3'd3,
    ACT_CIRCLE = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic load;
    logic start_clear;
    logic start_draw;
    logic rd_issue;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic in_grid;
  } dp_status_t;

endpackage

// ----- src/bsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bsr_datapath.sv -----
// Datapath: command fields, pixel scan counters, hit test pipeline and framebuffer.
module bsr_datapath
  import bsr_pkg::*;
#(
  parameter int GRID = GRID_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [ACT_W-1:0]   action,
  input  logic [FIELD_W-1:0] x_first,
  input  logic [FIELD_W-1:0] y_first,
  input  logic [FIELD_W-1:0] x_second,
  input  logic [FIELD_W-1:0] y_second,
  input  logic [FIELD_W-1:0] rect_length,
  input  logic [FIELD_W-1:0] rect_width,
  input  logic [FIELD_W-1:0] radius,
  output logic               pixel_value
);

  localparam int CW = $clog2(GRID);
  localparam int AW = $clog2(GRID * GRID);
  localparam int SW = ((CW > FIELD_W) ? CW : FIELD_W) + 2;
  localparam int PW = 2 * SW;
  localparam int RW = 2 * FIELD_W;
  localparam logic [CW-1:0] LAST = CW'(GRID - 1);
  localparam logic signed [PW+1:0] EPS = (PW+2)'(EPSILON);

  // command fields
  logic [ACT_W-1:0]   act_q;
  logic [FIELD_W-1:0] x1_q, y1_q, x2_q, y2_q, len_q, wid_q, r_q;

  // scan
  logic          active;
  logic          clr_mode;
  logic [CW-1:0] x_cnt, y_cnt;
  logic [AW-1:0] addr_cnt;

  // stage 1
  logic                 s1_v;
  logic [AW-1:0]        s1_addr;
  logic                 s1_rect, s1_vl, s1_lr;
  logic signed [SW-1:0] s1_ddx, s1_ddy;

  // stage 2
  logic                 s2_v;
  logic [AW-1:0]        s2_addr;
  logic                 s2_rect, s2_vl, s2_lr;
  logic signed [PW-1:0] s2_p1, s2_p2, s2_q1, s2_q2;
  logic [RW-1:0]        s2_rsq;

  // combinational
  logic signed [SW-1:0] xs, ys, x1s, y1s, x2s, y2s, lens, wids;
  logic signed [SW-1:0] dx, dyl;
  logic                 rect_c, vl_c, lr_c;
  logic signed [PW:0]   err, err_abs;
  logic signed [PW+1:0] err_dbl, dxw, circ_d;
  logic                 line_hit, circ_hit, hit;
  logic                 we;
  logic                 ram_rdata;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        rd_row;

  assign xs   = signed'(SW'(x_cnt));
  assign ys   = signed'(SW'(y_cnt));
  assign x1s  = signed'(SW'(x1_q));
  assign y1s  = signed'(SW'(y1_q));
  assign x2s  = signed'(SW'(x2_q));
  assign y2s  = signed'(SW'(y2_q));
  assign lens = signed'(SW'(len_q));
  assign wids = signed'(SW'(wid_q));
  assign dx   = x2s - x1s;
  assign dyl  = y2s - y1s;

  assign rect_c = (xs > x1s) && (xs < x1s + lens) && (ys > y1s) && (ys < y1s + wids);
  assign vl_c   = (xs == x1s) && (ys > y1s) && (ys < y2s);
  assign lr_c   = (dx > 0) && (xs >= x1s) && (xs <= x2s);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      x1_q  <= x_first;
      y1_q  <= y_first;
      x2_q  <= x_second;
      y2_q  <= y_second;
      len_q <= rect_length;
      wid_q <= rect_width;
      r_q   <= radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      clr_mode <= 1'b0;
      x_cnt    <= '0;
      y_cnt    <= '0;
      addr_cnt <= '0;
    end else if (cmd.start_clear || cmd.start_draw) begin
      active   <= 1'b1;
      clr_mode <= cmd.start_clear;
      x_cnt    <= '0;
      y_cnt    <= '0;
      addr_cnt <= '0;
    end else if (active) begin
      addr_cnt <= addr_cnt + AW'(1);
      if (x_cnt == LAST) begin
        x_cnt <= '0;
        y_cnt <= y_cnt + CW'(1);
        if (y_cnt == LAST) begin
          active <= 1'b0;
        end
      end else begin
        x_cnt <= x_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= active;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr_cnt;
    s1_rect <= rect_c;
    s1_vl   <= vl_c;
    s1_lr   <= lr_c;
    s1_ddx  <= xs - x1s;
    s1_ddy  <= ys - y1s;
    s2_addr <= s1_addr;
    s2_rect <= s1_rect;
    s2_vl   <= s1_vl;
    s2_lr   <= s1_lr;
    s2_p1   <= s1_ddy * dx;
    s2_p2   <= dyl * s1_ddx;
    s2_q1   <= s1_ddx * s1_ddx;
    s2_q2   <= s1_ddy * s1_ddy;
    s2_rsq  <= RW'(r_q) * RW'(r_q);
  end

  assign err      = (PW+1)'(s2_p1) - (PW+1)'(s2_p2);
  assign err_abs  = err[PW] ? -err : err;
  assign err_dbl  = (PW+2)'(err_abs) <<< 1;
  assign dxw      = (PW+2)'(dx);
  assign line_hit = s2_lr && (err_dbl < dxw);
  assign circ_d   = (PW+2)'(s2_q1) + (PW+2)'(s2_q2) - signed'((PW+2)'(s2_rsq));
  assign circ_hit = (circ_d < EPS) && (circ_d > -EPS);

  always_comb begin
    case (action_t'(act_q))
      ACT_RECT:   hit = s2_rect;
      ACT_LINE:   hit = line_hit;
      ACT_VLINE:  hit = s2_vl;
      ACT_CIRCLE: hit = circ_hit;
      default:    hit = 1'b0;
    endcase
  end

  assign we = s2_v && (clr_mode || hit);

  assign rd_row  = LAST - CW'(y1_q);
  assign rd_addr = AW'(rd_row) * AW'(GRID) + AW'(CW'(x1_q));

  bsr_ram #(
    .WIDTH(1),
    .DEPTH(GRID * GRID)
  ) u_fb (
    .clk  (clk),
    .we   (we),
    .waddr(s2_addr),
    .wdata(!clr_mode),
    .re   (cmd.rd_issue),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign status.busy    = active || s1_v || s2_v;
  assign status.in_grid = (int'(x1_q) < GRID) && (int'(y1_q) < GRID);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_value <= status.in_grid ? ram_rdata : 1'b0;
    end
  end

endmodule

// ----- src/bsr_ctrl.sv -----
// Controller: command dispatch, scan sequencing and output handshake.
module bsr_ctrl
  import bsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] action,
  output logic             out_valid,
  input  logic             out_ready,
  output ctrl_cmd_t        cmd,
  input  dp_status_t       status
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.start_clear = 1'b1;
        state_next      = S_SCAN;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (action_t'(action))
            ACT_CLEAR: begin
              cmd.start_clear = 1'b1;
              state_next      = S_SCAN;
            end
            ACT_RECT, ACT_LINE, ACT_VLINE, ACT_CIRCLE: begin
              cmd.start_draw = 1'b1;
              state_next     = S_SCAN;
            end
            ACT_READ: begin
              state_next = S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!status.busy) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

// ----- src/bitmap_shape_rasterizer.sv -----
// Top level of the bitmap shape rasterizer.
// One-bit GRID by GRID framebuffer held in a single-port-write RAM. After reset the
// block clears the whole framebuffer, one pixel per cycle, before in_ready first
// rises. Clear and every drawing command sweep all pixels in raster order through
// the hit-test pipeline, one pixel per cycle; the scan counter and the single RAM
// write port set that rate. The result of a read beat waits in the output register;
// drawing beats are still accepted while it waits.
// Actions 6 and 7 are accepted and leave the framebuffer and the output unchanged.
module bitmap_shape_rasterizer
  import bsr_pkg::*;
#(
  parameter int GRID = GRID_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   action,
  input  logic [FIELD_W-1:0] x_first,
  input  logic [FIELD_W-1:0] y_first,
  input  logic [FIELD_W-1:0] x_second,
  input  logic [FIELD_W-1:0] y_second,
  input  logic [FIELD_W-1:0] rect_length,
  input  logic [FIELD_W-1:0] rect_width,
  input  logic [FIELD_W-1:0] radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               pixel_value
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status)
  );

  bsr_datapath #(
    .GRID(GRID)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .action     (action),
    .x_first    (x_first),
    .y_first    (y_first),
    .x_second   (x_second),
    .y_second   (y_second),
    .rect_length(rect_length),
    .rect_width (rect_width),
    .radius     (radius),
    .pixel_value(pixel_value)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the bitmap shape rasterizer: random handshakes, framebuffer predictor.
module testbench;
  import bsr_pkg::*;

  localparam int GRID        = GRID_DEFAULT;
  localparam int PIXELS      = GRID * GRID;
  localparam int RANDOM_CMDS = 100;
  localparam int CYCLE_LIMIT = 6_000_000;

  localparam logic [ACT_W-1:0] ACT_UNUSED_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_B = 3'd7;

  typedef struct {
    logic [ACT_W-1:0]   act;
    logic [FIELD_W-1:0] x1, y1, x2, y2, len, wid, rad;
    bit                 aim;
    bit                 drain;
  } cmd_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [ACT_W-1:0]   action;
  logic [FIELD_W-1:0] x_first, y_first, x_second, y_second;
  logic [FIELD_W-1:0] rect_length, rect_width, radius;
  logic               out_valid;
  logic               out_ready;
  logic               pixel_value;

  cmd_t cmd_queue[$];
  bit   read_results_due[$];
  bit   frame_bits [PIXELS];

  bit   in_beat;
  int   beats_taken;
  int   send_idle;
  int   recv_idle;
  int   mismatches;
  int   cycle_count;

  bitmap_shape_rasterizer #(.GRID(GRID)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .x_first     (x_first),
    .y_first     (y_first),
    .x_second    (x_second),
    .y_second    (y_second),
    .rect_length (rect_length),
    .rect_width  (rect_width),
    .radius      (radius),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit shape_covers(logic [ACT_W-1:0] act, int x, int y, int x1, int y1,
                                      int x2, int y2, int len, int wid, int rad);
    int dx;
    int err;
    int d;
    dx = x2 - x1;
    case (act)
      ACT_RECT:   return x > x1 && x < x1 + len && y > y1 && y < y1 + wid;
      ACT_LINE: begin
        if (dx <= 0 || x < x1 || x > x2) return 1'b0;
        err = (y - y1) * dx - (y2 - y1) * (x - x1);
        if (err < 0) err = -err;
        return 2 * err < dx;
      end
      ACT_VLINE:  return x == x1 && y > y1 && y < y2;
      ACT_CIRCLE: begin
        d = (x - x1) * (x - x1) + (y - y1) * (y - y1) - rad * rad;
        if (d < 0) d = -d;
        return d < EPSILON;
      end
      default:    return 1'b0;
    endcase
  endfunction

  task automatic paint_shape();
    for (int y = 0; y < GRID; y++)
      for (int x = 0; x < GRID; x++)
        if (shape_covers(action, x, y, int'(x_first), int'(y_first), int'(x_second),
                         int'(y_second), int'(rect_length), int'(rect_width),
                         int'(radius)))
          frame_bits[y * GRID + x] = 1'b1;
  endtask

  function automatic bit pixel_at(int col, int disp_row);
    if (col >= GRID || disp_row >= GRID) return 1'b0;
    return frame_bits[(GRID - 1 - disp_row) * GRID + col];
  endfunction

  task automatic queue_cmd(logic [ACT_W-1:0] act, int x1, int y1, int x2, int y2,
                           int len, int wid, int rad, bit drain);
    cmd_t c;
    c.act   = act;
    c.x1    = FIELD_W'(x1);
    c.y1    = FIELD_W'(y1);
    c.x2    = FIELD_W'(x2);
    c.y2    = FIELD_W'(y2);
    c.len   = FIELD_W'(len);
    c.wid   = FIELD_W'(wid);
    c.rad   = FIELD_W'(rad);
    c.aim   = 1'b0;
    c.drain = drain;
    cmd_queue.push_back(c);
  endtask

  // Monitor and predictor.
  always @(posedge clk) begin : monitor
    bit due;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_shape_rasterizer verification failed");
      $finish;
    end else begin
      in_beat = 1'b0;
      if (!rst) begin
        if (out_valid && out_ready) begin
          if (read_results_due.size() == 0) begin
            $display("%0t: unexpected beat, pixel_value=%0b, expected none",
                     $time, pixel_value);
            mismatches++;
          end else begin
            due = read_results_due.pop_front();
            if (pixel_value !== due) begin
              $display("%0t: pixel_value expected %0b got %0b", $time, due, pixel_value);
              mismatches++;
            end
          end
        end
        if (in_valid && in_ready) begin
          in_beat = 1'b1;
          beats_taken++;
          case (action)
            ACT_CLEAR: foreach (frame_bits[i]) frame_bits[i] = 1'b0;
            ACT_READ:  read_results_due.push_back(pixel_at(int'(x_first), int'(y_first)));
            ACT_RECT, ACT_LINE, ACT_VLINE, ACT_CIRCLE: paint_shape();
            default: ;
          endcase
        end
      end
      if (beats_taken < 42) begin
        send_idle = 23;
        recv_idle = 45;
      end else if (beats_taken < 84) begin
        send_idle = 45;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
    end
  end

  // Driver.
  always @(negedge clk) begin : driver
    cmd_t nxt;
    int   start;
    int   k;
    int   fx;
    int   fy;
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (!in_valid || in_beat) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle &&
            !(cmd_queue[0].drain && read_results_due.size() > 0)) begin
          nxt = cmd_queue.pop_front();
          if (nxt.aim) begin
            start = $urandom_range(PIXELS - 1);
            k = 0;
            while (k < PIXELS && !frame_bits[(start + k) % PIXELS]) k++;
            if (k < PIXELS) begin
              fx = (start + k) % PIXELS % GRID;
              fy = (start + k) % PIXELS / GRID;
              if ($urandom_range(1)) begin
                fx = fx + int'($urandom_range(2)) - 1;
                fy = fy + int'($urandom_range(2)) - 1;
              end
              if (fx >= 0 && fx < GRID && fy >= 0 && fy < GRID) begin
                nxt.x1 = FIELD_W'(fx);
                nxt.y1 = FIELD_W'(GRID - 1 - fy);
              end
            end
          end
          action      <= nxt.act;
          x_first     <= nxt.x1;
          y_first     <= nxt.y1;
          x_second    <= nxt.x2;
          y_second    <= nxt.y2;
          rect_length <= nxt.len;
          rect_width  <= nxt.wid;
          radius      <= nxt.rad;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    cmd_t c;
    int   n;
    int   pick;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    action      = ACT_CLEAR;
    x_first     = '0;
    y_first     = '0;
    x_second    = '0;
    y_second    = '0;
    rect_length = '0;
    rect_width  = '0;
    radius      = '0;
    in_beat     = 1'b0;
    beats_taken = 0;
    send_idle   = 23;
    recv_idle   = 45;
    mismatches  = 0;
    cycle_count = 0;
    foreach (frame_bits[i]) frame_bits[i] = 1'b0;

    queue_cmd(ACT_READ,     0,   0,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_RECT,    10,  20,   0,   0,  10,   5,   0, 0);
    queue_cmd(ACT_READ,    15, 105,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_READ,    10, 107,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_LINE,     0,   0, 127, 127,   0,   0,   0, 0);
    queue_cmd(ACT_READ,    64,  63,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_LINE,    90,   5,  20, 100,   0,   0,   0, 0);
    queue_cmd(ACT_LINE,    40,  10,  40,  90,   0,   0,   0, 0);
    queue_cmd(ACT_READ,    90, 122,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_VLINE,  127,   0,   0, 127,   0,   0,   0, 0);
    queue_cmd(ACT_READ,   127,   0,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_READ,   127,   1,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_CIRCLE,   0,   0,   0,   0,   0,   0, 127, 0);
    queue_cmd(ACT_CIRCLE,  64,  64,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_READ,    64,  63,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_CIRCLE, 127, 127,   0,   0,   0,   0, 127, 0);
    queue_cmd(ACT_UNUSED_A, 127, 127, 127, 127, 127, 127, 127, 0);
    queue_cmd(ACT_UNUSED_B,   0,   0,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_RECT,   127, 127,   0,   0, 127, 127,   0, 0);
    queue_cmd(ACT_RECT,     0,   0,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_READ,     0, 127,   0,   0,   0,   0,   0, 1);
    queue_cmd(ACT_CLEAR,    0,   0,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_READ,    15, 105,   0,   0,   0,   0,   0, 0);
    queue_cmd(ACT_READ,   127, 127,   0,   0,   0,   0,   0, 0);

    n = 0;
    while (n < RANDOM_CMDS) begin
      c.x1    = FIELD_W'($urandom_range(127));
      c.y1    = FIELD_W'($urandom_range(127));
      c.x2    = FIELD_W'($urandom_range(127));
      c.y2    = FIELD_W'($urandom_range(127));
      c.len   = FIELD_W'($urandom_range(127));
      c.wid   = FIELD_W'($urandom_range(127));
      c.rad   = FIELD_W'($urandom_range(127));
      c.aim   = 1'b0;
      c.drain = ($urandom_range(99) < 3);
      pick    = $urandom_range(99);
      if (pick < 4) begin
        c.act = $urandom_range(1) ? ACT_UNUSED_A : ACT_UNUSED_B;
      end else if (pick < 22) begin
        n++;
        case ($urandom_range(9))
          0:       c.act = ACT_CLEAR;
          1, 2:    c.act = ACT_RECT;
          3, 4:    c.act = ACT_LINE;
          5, 6:    c.act = ACT_VLINE;
          default: c.act = ACT_CIRCLE;
        endcase
        if (c.act == ACT_LINE && $urandom_range(9) < 8) begin
          c.x1 = FIELD_W'($urandom_range(126));
          c.x2 = FIELD_W'($urandom_range(127, c.x1 + 1));
        end
        if (c.act == ACT_VLINE && $urandom_range(9) < 8) begin
          c.y1 = FIELD_W'($urandom_range(126));
          c.y2 = FIELD_W'($urandom_range(127, c.y1 + 1));
        end
        if (c.act == ACT_CIRCLE && $urandom_range(1)) c.rad = FIELD_W'($urandom_range(40));
      end else begin
        n++;
        c.act = ACT_READ;
        c.aim = ($urandom_range(9) < 6);
      end
      cmd_queue.push_back(c);
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (cmd_queue.size() > 0 || in_valid) @(posedge clk);
    while (read_results_due.size() > 0) @(posedge clk);
    repeat (PIXELS + 64) @(posedge clk);
    if (mismatches == 0) begin
      $display("bitmap_shape_rasterizer verification clean");
    end else begin
      $display("bitmap_shape_rasterizer verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bsr_pkg.sv
src/bsr_ram.sv
src/bsr_datapath.sv
src/bsr_ctrl.sv
src/bitmap_shape_rasterizer.sv
tb/testbench.sv
